>>> src/cts_pkg.sv
// Shared constants, types and state codes for the CPU tick share engine.
`timescale 1ns / 1ps

package cts_pkg;

    localparam int ENTRY_W       = 6;     // slot number width on the ports
    localparam int TICK_W        = 64;    // one cumulative tick counter
    localparam int SHARE_W       = 14;    // share in hundredths of a percent
    localparam int NCAT          = 8;     // tick categories per word
    localparam int CAT_W         = 3;     // category index width
    localparam int NSHARE        = NCAT + 1;          // categories plus busy
    localparam int CNT_W         = $clog2(NSHARE + 1); // counts 0 .. NSHARE
    localparam int BIT_W         = $clog2(SHARE_W);    // quotient bit counter
    localparam int PROD_W        = TICK_W + SHARE_W;   // delta times full scale
    localparam int DEFAULT_SLOTS = 64;

    // Category indexes as they appear in the input word
    localparam logic [CAT_W-1:0] CAT_IDLE   = 3'd3;
    localparam logic [CAT_W-1:0] CAT_IOWAIT = 3'd4;
    localparam logic [CNT_W-1:0] IDX_BUSY   = 4'd8;

    localparam logic [SHARE_W-1:0] FULL_SCALE = 14'd10000;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WRITE = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_BUSY  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

endpackage

>>> src/cts_if.sv
// Input and result channel interfaces of the CPU tick share engine.
`timescale 1ns / 1ps

interface cts_in_if import cts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] entry;
    logic               present;
    logic [TICK_W-1:0]  user_ticks;
    logic [TICK_W-1:0]  nice_ticks;
    logic [TICK_W-1:0]  system_ticks;
    logic [TICK_W-1:0]  idle_ticks;
    logic [TICK_W-1:0]  iowait_ticks;
    logic [TICK_W-1:0]  irq_ticks;
    logic [TICK_W-1:0]  softirq_ticks;
    logic [TICK_W-1:0]  steal_ticks;

    modport source (
        output valid, entry, present, user_ticks, nice_ticks, system_ticks,
               idle_ticks, iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
        input  ready
    );
    modport sink (
        input  valid, entry, present, user_ticks, nice_ticks, system_ticks,
               idle_ticks, iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
        output ready
    );
endinterface

interface cts_out_if import cts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] slot;
    logic               sample_valid;
    logic [SHARE_W-1:0] user_share;
    logic [SHARE_W-1:0] nice_share;
    logic [SHARE_W-1:0] system_share;
    logic [SHARE_W-1:0] idle_share;
    logic [SHARE_W-1:0] iowait_share;
    logic [SHARE_W-1:0] irq_share;
    logic [SHARE_W-1:0] softirq_share;
    logic [SHARE_W-1:0] steal_share;
    logic [SHARE_W-1:0] busy_share;

    modport source (
        output valid, slot, sample_valid, user_share, nice_share, system_share,
               idle_share, iowait_share, irq_share, softirq_share, steal_share,
               busy_share,
        input  ready
    );
    modport sink (
        input  valid, slot, sample_valid, user_share, nice_share, system_share,
               idle_share, iowait_share, irq_share, softirq_share, steal_share,
               busy_share,
        output ready
    );
endinterface

>>> src/cts_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module cts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cpu_tick_share_engine_top.sv
// CPU tick share engine: per-slot tick deltas turned into shares of the total.
//
// Usage: i_in takes one word per sample: a slot number, a present flag and
// eight cumulative tick counters. o_out returns exactly one word per input
// word: the slot, a sample-valid flag and nine shares in 0.01 % (eight
// categories plus busy). Both channels move a word when valid and ready are
// high at a rising edge.
// i_in is ready only while the sequencer is idle; one word is worked on at a
// time. An absent CPU or an out-of-range slot goes straight to S_FIN; first
// sight of a slot writes the eight baselines; a total that drops or stays
// gives a word without a sample. A full sample runs all nine shares through
// the single shared divider: each share takes a multiply step plus a 14-bit
// restoring division, or the multiply step alone when the delta reaches the
// total. Baselines live in one RAM of 8 x SLOTS 64-bit words; the per-slot
// valid flags are flip-flops cleared at reset, so no clearing pass is needed.
// Results sit in an output register; a new word is accepted while the last
// result waits, and the sequencer holds its next result until o_out frees.
`timescale 1ns / 1ps

module cpu_tick_share_engine_top import cts_pkg::*; #(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cts_in_if.sink    i_in,
    cts_out_if.source o_out
);

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RAM_DEPTH = SLOTS * NCAT;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_valid;
    logic [CNT_W-1:0]    r_cnt;
    logic [BIT_W-1:0]    r_bit;
    logic                r_ov;

    logic [ENTRY_W-1:0]  r_slot;
    logic [SLOT_W-1:0]   r_idx;
    logic [TICK_W-1:0]   r_cur [NCAT];
    logic [TICK_W-1:0]   r_d   [NSHARE];
    logic [TICK_W-1:0]   r_acc_cur, r_acc_prev, r_idle, r_dt, r_rem;
    logic [SHARE_W-1:0]  r_low, r_q;
    logic [SHARE_W-1:0]  r_share [NSHARE];
    logic                r_has;

    logic [ENTRY_W-1:0]  r_o_slot;
    logic                r_o_has;
    logic [SHARE_W-1:0]  r_o_share [NSHARE];

    logic [TICK_W-1:0]   w_in_ticks [NCAT];
    logic [SLOT_W-1:0]   w_in_idx;
    logic                w_in_range;
    logic                w_accept;
    logic                w_load_out;
    logic [CAT_W-1:0]    w_k;
    logic [TICK_W-1:0]   w_rdata;
    logic                w_we, w_re;
    logic [CAT_W-1:0]    w_wcat;
    logic [RAM_AW-1:0]   w_waddr, w_raddr;
    logic [TICK_W-1:0]   w_delta;
    logic [TICK_W:0]     w_tdiff;
    logic [TICK_W-1:0]   w_dsel;
    logic                w_full;
    logic [PROD_W-1:0]   w_prod;
    logic [TICK_W:0]     w_shift, w_sub;
    logic                w_ge;

    // Input word fields in category order
    assign w_in_ticks[0] = i_in.user_ticks;
    assign w_in_ticks[1] = i_in.nice_ticks;
    assign w_in_ticks[2] = i_in.system_ticks;
    assign w_in_ticks[3] = i_in.idle_ticks;
    assign w_in_ticks[4] = i_in.iowait_ticks;
    assign w_in_ticks[5] = i_in.irq_ticks;
    assign w_in_ticks[6] = i_in.softirq_ticks;
    assign w_in_ticks[7] = i_in.steal_ticks;

    assign w_in_idx   = SLOT_W'(i_in.entry);
    assign w_in_range = (32'(i_in.entry) < SLOTS);
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load_out = (r_state == S_FIN) && (!r_ov || o_out.ready);

    // Baseline RAM: write back in WRITE, and in READ in the cycle after each read
    assign w_k     = CAT_W'(r_cnt - CNT_W'(1));
    assign w_re    = (r_state == S_READ) && (r_cnt < CNT_W'(NCAT));
    assign w_we    = (r_state == S_WRITE) ||
                     ((r_state == S_READ) && (r_cnt != '0));
    assign w_wcat  = (r_state == S_WRITE) ? r_cnt[CAT_W-1:0] : w_k;
    assign w_waddr = RAM_AW'({r_idx, w_wcat});
    assign w_raddr = RAM_AW'({r_idx, r_cnt[CAT_W-1:0]});

    cts_ram #(
        .WIDTH (TICK_W),
        .DEPTH (RAM_DEPTH)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_cur[w_wcat]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Delta of the category whose baseline just came back
    assign w_delta = r_cur[w_k] - w_rdata;
    // Total delta with borrow: a set borrow means the total dropped
    assign w_tdiff = {1'b0, r_acc_cur} - {1'b0, r_acc_prev};

    // Shared divider: multiply once, then one quotient bit per cycle
    assign w_dsel  = r_d[r_cnt];
    assign w_full  = (w_dsel >= r_dt);
    assign w_prod  = {{SHARE_W{1'b0}}, w_dsel} * PROD_W'(FULL_SCALE);
    assign w_shift = {r_rem, r_low[SHARE_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dt});
    assign w_sub   = w_shift - {1'b0, r_dt};

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_in_range || !i_in.present) begin
                        n_state = S_FIN;
                    end else if (!r_valid[w_in_idx]) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: begin
                if (r_cnt == CNT_W'(NCAT - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                if (r_cnt == CNT_W'(NCAT)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_tdiff[TICK_W] || (w_tdiff[TICK_W-1:0] == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: n_state = S_MUL;
            S_MUL: begin
                if (!w_full) begin
                    n_state = S_DIV;
                end else if (r_cnt == IDX_BUSY) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (r_bit == BIT_W'(SHARE_W - 1)) begin
                    n_state = (r_cnt == IDX_BUSY) ? S_FIN : S_MUL;
                end
            end
            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_cnt   <= '0;
            r_bit   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept && w_in_range) begin
                        r_valid[w_in_idx] <= i_in.present;
                    end
                end
                S_WRITE, S_READ: r_cnt <= r_cnt + CNT_W'(1);
                S_BUSY:          r_cnt <= '0;
                S_MUL: begin
                    r_bit <= '0;
                    if (w_full) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(SHARE_W - 1)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_slot     <= i_in.entry;
                    r_idx      <= w_in_idx;
                    r_has      <= 1'b0;
                    r_acc_cur  <= '0;
                    r_acc_prev <= '0;
                    r_idle     <= '0;
                    for (int i = 0; i < NCAT; i++) begin
                        r_cur[i] <= w_in_ticks[i];
                    end
                    for (int i = 0; i < NSHARE; i++) begin
                        r_share[i] <= '0;
                    end
                end
            end
            S_READ: begin
                if (r_cnt != '0) begin
                    r_d[CNT_W'(w_k)] <= w_delta;
                    r_acc_cur  <= r_acc_cur + r_cur[w_k];
                    r_acc_prev <= r_acc_prev + w_rdata;
                    if ((w_k == CAT_IDLE) || (w_k == CAT_IOWAIT)) begin
                        r_idle <= r_idle + w_delta;
                    end
                end
            end
            S_CHECK: r_dt <= w_tdiff[TICK_W-1:0];
            S_BUSY: begin
                r_d[IDX_BUSY] <= r_dt - r_idle;
                r_has         <= 1'b1;
            end
            S_MUL: begin
                if (w_full) begin
                    r_share[r_cnt] <= FULL_SCALE;
                end
                // delta < total, so the upper product bits stay below the total
                r_rem <= w_prod[PROD_W-1:SHARE_W];
                r_low <= w_prod[SHARE_W-1:0];
                r_q   <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_sub[TICK_W-1:0] : w_shift[TICK_W-1:0];
                r_low <= {r_low[SHARE_W-2:0], 1'b0};
                r_q   <= {r_q[SHARE_W-2:0], w_ge};
                if (r_bit == BIT_W'(SHARE_W - 1)) begin
                    r_share[r_cnt] <= {r_q[SHARE_W-2:0], w_ge};
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_slot <= r_slot;
            r_o_has  <= r_has;
            for (int i = 0; i < NSHARE; i++) begin
                r_o_share[i] <= r_share[i];
            end
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.slot          = r_o_slot;
    assign o_out.sample_valid  = r_o_has;
    assign o_out.user_share    = r_o_share[0];
    assign o_out.nice_share    = r_o_share[1];
    assign o_out.system_share  = r_o_share[2];
    assign o_out.idle_share    = r_o_share[3];
    assign o_out.iowait_share  = r_o_share[4];
    assign o_out.irq_share     = r_o_share[5];
    assign o_out.softirq_share = r_o_share[6];
    assign o_out.steal_share   = r_o_share[7];
    assign o_out.busy_share    = r_o_share[8];

`ifndef SYNTHESIS
    // Sequencer always holds exactly one state
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    // An accepted word blocks the input until its result is loaded into the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after accept");

    // Division remainder stays below the total delta
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dt))
        else $error("divider remainder out of range");

    // A word without a sample carries all-zero shares
    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.sample_valid) |->
            ((o_out.user_share == '0) && (o_out.idle_share == '0) &&
             (o_out.busy_share == '0) && (o_out.steal_share == '0)))
        else $error("shares set without a sample");
`endif

endmodule
